FILE: hw/rtl/f2d_pkg.sv
// shared types and constants of the fixed-point to binary64 converter
package f2d_pkg;

    localparam int WORD_BITS = 64;
    localparam int MANT_BITS = 52;
    localparam int EXP_BITS  = 11;
    localparam int EXP_BIAS  = 1023;
    localparam int CFG_BITS  = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_SIGNED = 2'd1;
    localparam logic [1:0] CFG_FRACTION_BITS = 2'd2;

    // load enables of the back stages, one per register stage
    typedef struct packed {
        logic norm;
        logic shift;
        logic pack;
    } stage_en_t;

endpackage

FILE: hw/rtl/f2d_round.sv
// leading-one search, normalize, round to nearest even and pack into binary64
module f2d_round (
    input  logic                aclk,
    input  f2d_pkg::stage_en_t  en,
    input  logic [63:0]         mag,
    input  logic [5:0]          frac_shift,
    input  logic                sgn,
    output logic [63:0]         double_bits
);
    import f2d_pkg::*;

    // stage: leading-one position
    logic [63:0] mag_reg;
    logic [5:0]  e_reg;
    logic        sgn_reg;
    logic [5:0]  pos_reg, pos_next;
    logic        zero_reg;

    // stage: normalize
    logic [63:0]         norm_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic                sgn2_reg;
    logic                zero2_reg;

    // stage: round and pack
    logic [63:0] bits_reg, bits_next;

    logic [52:0] keep;
    logic [53:0] sum;
    logic        guard, sticky, up;

    always_comb begin
        pos_next = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (mag[i]) begin
                pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.norm) begin
            mag_reg  <= mag;
            e_reg    <= frac_shift;
            sgn_reg  <= sgn;
            pos_reg  <= pos_next;
            zero_reg <= (mag == '0);
        end
        if (en.shift) begin
            norm_reg  <= mag_reg << (6'd63 - pos_reg);
            exp_reg   <= EXP_BITS'(pos_reg) + EXP_BITS'(EXP_BIAS) - EXP_BITS'(e_reg);
            sgn2_reg  <= sgn_reg;
            zero2_reg <= zero_reg;
        end
        if (en.pack) begin
            bits_reg <= bits_next;
        end
    end

    always_comb begin
        keep   = norm_reg[63:11];
        guard  = norm_reg[10];
        sticky = |norm_reg[9:0];
        up     = guard && (sticky || keep[0]);
        sum    = {1'b0, keep} + 54'(up);
        if (zero2_reg) begin
            bits_next = '0;
        end else if (sum[53]) begin
            // carry out of the mantissa: next binade
            bits_next = {sgn2_reg, exp_reg + 11'd1, 52'd0};
        end else begin
            bits_next = {sgn2_reg, exp_reg, sum[MANT_BITS-1:0]};
        end
    end

    assign double_bits = bits_reg;

endmodule

FILE: hw/rtl/fixed_point_to_double.sv
// top level: configurable fixed-point word to ieee-754 binary64 converter
//
//  channel | direction | beat contents                 | handshake
//  --------+-----------+-------------------------------+----------------------
//  s_      | in        | raw_value (64 bits)           | s_valid / s_ready
//  m_      | out       | double_bits (64 bits)         | m_valid / m_ready
//  cfg_    | in        | cfg_index (2), cfg_data (7)   | cfg_valid / cfg_ready
//
//  six register stages: decode, split, select, leading-one, normalize, round/pack
//  one beat per cycle sustained while m_ready is high; m_valid shows round/pack holds a beat
//  every stage has its own valid bit and loads when it is empty or moves on,
//  so bubbles close up while the output waits and nothing is lost or repeated
//  aresetn (synchronous) clears valid bits and restores the register defaults
//  cfg_ready is always high; writes are expected only while the pipe is empty
module fixed_point_to_double (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_raw_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_double_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import f2d_pkg::*;

    localparam int STAGES = 6;

    // configuration registers
    logic [CFG_BITS-1:0] width_reg;
    logic                signed_reg;
    logic [CFG_BITS-1:0] frac_reg;

    // per-stage valid bits and load enables
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] ld;

    // decode stage
    logic [6:0]  w_eff;
    logic [5:0]  w_m1;
    logic [63:0] wmask;
    logic        neg_next;
    logic [63:0] x_next;
    logic [6:0]  f_lim;
    logic [5:0]  f_next;

    logic [63:0] x_reg;
    logic        neg_reg;
    logic [5:0]  f_reg;

    // split stage: whole part magnitude, fraction, full magnitude
    logic [63:0] whole_reg;
    logic [63:0] fpart_reg;
    logic [63:0] amag_reg;
    logic [63:0] half_reg;
    logic        neg2_reg;
    logic [5:0]  f2_reg;
    logic [63:0] lowf;

    // select stage: which magnitude and scale go to rounding
    logic [63:0] mag_reg, mag_next;
    logic [5:0]  e_reg, e_next;
    logic        sgn_reg, sgn_next;

    localparam logic [63:0] TWO_POW_53 = 64'(1) << (MANT_BITS + 1);

    stage_en_t back_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd32;
            signed_reg <= 1'b1;
            frac_reg   <= 7'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                CFG_SOURCE_SIGNED: signed_reg <= cfg_data[0];
                CFG_FRACTION_BITS: frac_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        ld[STAGES-1] = !v_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    assign s_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (ld[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // decode: clamp width and fraction count, mask and sign-extend the word
    always_comb begin
        if (width_reg == 7'd0) begin
            w_eff = 7'd1;
        end else if (width_reg > 7'd64) begin
            w_eff = 7'd64;
        end else begin
            w_eff = width_reg;
        end
        w_m1     = 6'(w_eff - 7'd1);
        wmask    = ~64'd0 >> (6'd63 - w_m1);
        neg_next = signed_reg && s_raw_value[w_m1];
        x_next   = neg_next ? (s_raw_value | ~wmask) : (s_raw_value & wmask);
        f_lim    = signed_reg ? {1'b0, w_m1} : w_eff;
        if (f_lim > 7'(MANT_BITS)) begin
            f_lim = 7'(MANT_BITS);
        end
        f_next = (frac_reg > f_lim) ? 6'(f_lim) : 6'(frac_reg);
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            x_reg   <= x_next;
            neg_reg <= neg_next;
            f_reg   <= f_next;
        end
    end

    // split: floor part magnitude and the fraction bits
    assign lowf = ~(~64'd0 << f_reg);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            whole_reg <= neg_reg ? ((~x_reg >> f_reg) + 64'd1) : (x_reg >> f_reg);
            fpart_reg <= x_reg & lowf;
            amag_reg  <= neg_reg ? (~x_reg + 64'd1) : x_reg;
            half_reg  <= (64'd1 << f_reg) >> 1;
            neg2_reg  <= neg_reg;
            f2_reg    <= f_reg;
        end
    end

    // select: small whole part rounds the exact value once; a large whole part
    // is rounded alone and the fraction cannot move it, except just past 2^53
    // on the negative side where the step below is one
    always_comb begin
        if (whole_reg <= TWO_POW_53) begin
            mag_next = amag_reg;
            e_next   = f2_reg;
            sgn_next = neg2_reg;
        end else if (neg2_reg && (whole_reg == TWO_POW_53 + 64'd1)) begin
            mag_next = (fpart_reg > half_reg) ? (TWO_POW_53 - 64'd1) : TWO_POW_53;
            e_next   = '0;
            sgn_next = 1'b1;
        end else begin
            mag_next = whole_reg;
            e_next   = '0;
            sgn_next = neg2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            mag_reg <= mag_next;
            e_reg   <= e_next;
            sgn_reg <= sgn_next;
        end
    end

    assign back_en.norm  = ld[3];
    assign back_en.shift = ld[4];
    assign back_en.pack  = ld[5];

    f2d_round u_round (
        .aclk        (aclk),
        .en          (back_en),
        .mag         (mag_reg),
        .frac_shift  (e_reg),
        .sgn         (sgn_reg),
        .double_bits (m_double_bits)
    );

    assign m_valid = v_reg[STAGES-1];

`ifndef SYNTH
    // an empty output stage means the whole pipe can take a beat
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while output stage empty");

    // an accepted beat lands in the decode stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted beat lost at decode stage");

    // effective fraction count never exceeds the mantissa width
    a_frac_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] |-> f_reg <= 6'(MANT_BITS))
        else $error("fraction count not clamped");

    // results are zero or normal, never subnormal
    a_no_subnormal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_double_bits[62:52] == 11'd0) |-> m_double_bits == 64'd0)
        else $error("subnormal or negative zero result");
`endif

endmodule

FILE: bench/fixed_point_to_double_tb.sv
// testbench of the fixed-point to binary64 converter: random and directed beats, scoreboard
`timescale 1ns / 100ps

module fixed_point_to_double_tb;
    import f2d_pkg::*;

    // expected binary64 patterns, worked out from the raw words accepted so far
    class double_scoreboard;
        logic [6:0]  width_reg;
        logic        signed_reg;
        logic [6:0]  frac_reg;
        logic [63:0] expected_bits[$];

        function new();
            width_reg  = 7'd32;
            signed_reg = 1'b1;
            frac_reg   = 7'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [6:0] data);
            case (idx)
                CFG_SOURCE_WIDTH:  width_reg  = data;
                CFG_SOURCE_SIGNED: signed_reg = data[0];
                CFG_FRACTION_BITS: frac_reg   = data;
                default: ;
            endcase
        endfunction

        static function logic [63:0] ones_below(int n);
            if (n >= 64) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        // magnitude to real, nearest-even rounding to 53 significant bits
        static function real round_magnitude(logic [63:0] m);
            int p, sh;
            logic [63:0] keep, rem, half;
            p = 0;
            if (m == 0) return 0.0;
            while (p < 63 && (m >> (p + 1)) != 0) p++;
            if (p <= MANT_BITS) return real'(m);
            sh   = p - MANT_BITS;
            keep = m >> sh;
            rem  = m & ones_below(sh);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0])) keep++;
            if (keep == (64'd1 << (MANT_BITS + 1))) begin
                keep = keep >> 1;
                sh++;
            end
            return real'(keep) * (2.0 ** sh);
        endfunction

        function void note_input(logic [63:0] raw);
            int w, f;
            logic [63:0] x, frac, whole;
            logic neg;
            real wd, res;
            w = width_reg;
            f = frac_reg;
            neg = 1'b0;
            if (w == 0) w = 1;
            if (w > 64) w = 64;
            x = raw & ones_below(w);
            if (signed_reg) begin
                if (f >= w) f = w - 1;
                if (f > MANT_BITS) f = MANT_BITS;
                if (x[w-1]) begin
                    x = x | ~ones_below(w);
                    neg = 1'b1;
                end
            end else begin
                if (f > w) f = w;
                if (f > MANT_BITS) f = MANT_BITS;
            end
            frac  = x & ones_below(f);
            whole = neg ? ((~x) >> f) + 64'd1 : x >> f;
            wd = round_magnitude(whole);
            if (neg) wd = -wd;
            res = wd + real'(frac) / (2.0 ** f);
            expected_bits.push_back($realtobits(res));
        endfunction

        // returns 1 when got matches the oldest expectation
        function bit check_result(logic [63:0] got, output logic [63:0] want,
                                  output bit orphan);
            orphan = (expected_bits.size() == 0);
            want = '0;
            if (orphan) return 1'b0;
            want = expected_bits.pop_front();
            return got === want;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_raw_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_double_bits;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    double_scoreboard sb;
    int  error_count;
    bit  idling_on;
    int  sink_stall;

    fixed_point_to_double uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_raw_value(s_raw_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_double_bits(m_double_bits),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // input side: note each accepted beat in the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_raw_value);
    end

    // output side: random stall bursts on m_ready, check every accepted beat
    always @(posedge aclk) begin
        logic [63:0] want;
        bit orphan;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_result(m_double_bits, want, orphan))
                report(orphan ? "unexpected beat" : "double_bits", m_double_bits, want);
        end
        if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= (sink_stall == 0);
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(1, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one input beat; an idle burst may come first, valid stays up between beats
    task automatic send_word(logic [63:0] v);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_raw_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // one edge first so the last accepted beat is already noted
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_bits.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // write all three registers, only with the pipe empty
    task automatic set_config(logic [6:0] w, logic sgn, logic [6:0] f);
        logic [6:0] vals[3];
        logic [1:0] idxs[3];
        vals = '{w, {6'd0, sgn}, f};
        idxs = '{CFG_SOURCE_WIDTH, CFG_SOURCE_SIGNED, CFG_FRACTION_BITS};
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // random word shaped toward the sign bit and the binary point
    function automatic logic [63:0] random_word();
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(0, 63));
            2: begin
                k = $urandom_range(0, 63);
                v = 64'd1 << k;
            end
            3: v = {$urandom_range(0, 1) ? 32'hffffffff : 32'h0, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    // run limit
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        // width, signed, fraction per phase; extremes of all three registers
        logic [6:0] cw[14];
        logic       cs[14];
        logic [6:0] cf[14];
        cw = '{7'd64, 7'd64, 7'd1, 7'd1, 7'd0, 7'd127, 7'd127,
               7'd53, 7'd54, 7'd16, 7'd40, 7'd64, 7'd8, 7'd33};
        cs = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
               1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        cf = '{7'd0, 7'd52, 7'd0, 7'd1, 7'd127, 7'd64, 7'd127,
               7'd53, 7'd52, 7'd8, 7'd20, 7'd11, 7'd8, 7'd32};
        sb = new();
        error_count = 0;
        idling_on = 1'b1;
        sink_stall = 0;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_raw_value = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SOURCE_WIDTH;
        cfg_data = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults (32-bit signed, integer)
        send_word(64'h0);
        send_word(64'h7fffffff);
        send_word(64'h80000000);
        send_word(64'hffffffff);
        send_word(64'hdeadbeef_00000001);   // unused upper bits ignored
        // full unsigned width keeps bit 63, rounding ties around 2^53
        set_config(7'd64, 1'b0, 7'd0);
        send_word('1);
        send_word(64'h8000000000000000);
        send_word(64'h0020000000000001);
        send_word(64'h0020000000000003);
        send_word(64'h0);
        // signed 64 with fraction clamped to 52
        set_config(7'd64, 1'b1, 7'd127);
        send_word(64'h8000000000000000);
        send_word(64'h7fffffffffffffff);
        send_word('1);
        send_word(64'h000fffffffffffff);
        // width zero acts as one bit
        set_config(7'd0, 1'b1, 7'd5);
        send_word(64'h1);
        send_word(64'hfffffffffffffffe);
        set_config(7'd1, 1'b0, 7'd1);
        send_word(64'h1);
        send_word(64'h0);

        // random phases over several settings
        for (int p = 0; p < 14; p++) begin
            set_config(cw[p], cs[p], cf[p]);
            if (p >= 12) idling_on = 1'b0;   // last part runs at full rate
            for (int n = 0; n < 128; n++) begin
                send_word(random_word());
                if (p == 3 && n == 64) begin
                    // hold off until every expected beat is back
                    s_valid <= 1'b0;
                    while (sb.expected_bits.size() != 0) @(posedge aclk);
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
